// ===== design/ucd_pkg.sv =====
// shared types and constants for the undirected cycle detector
// used by ucd_ctrl, ucd_datapath and undirected_cycle_detect_core
`default_nettype none
package ucd_pkg;

  localparam int DEF_MAX_VERTICES = 1024;
  localparam int DEF_MAX_DEGREE   = 16;
  localparam int VTX_W            = 10;
  localparam int CNT_W            = 11;
  localparam int IN_W             = 32;
  localparam int OUT_W            = 8;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_LOAD,
    ST_R_RD,
    ST_R_CHK,
    ST_Q_RD,
    ST_Q_DAT,
    ST_L_DAT,
    ST_N_RD,
    ST_N_DAT,
    ST_V_CHK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept_ok;
    logic clr_en;
    logic walk_init;
    logic root_rd;
    logic root_mark;
    logic root_next;
    logic q_rd;
    logic cur_load;
    logic len_load;
    logic n_rd;
    logic nb_take;
    logic mark_nb;
    logic found;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic last_pending;
    logic clr_last;
    logic root_end;
    logic vis_set;
    logic q_empty;
    logic k_end;
    logic nb_skip;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

// ===== design/ucd_ctrl.sv =====
// controller state machine for the undirected cycle detector
// depends on ucd_pkg; drives the datapath through cmd_t, reads status_t
`default_nettype none
module ucd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ucd_pkg::status_t  st,
  output ucd_pkg::cmd_t          cmd,
  output ucd_pkg::state_t        state
);
  import ucd_pkg::*;

  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (st.clr_last) state_next = ST_LOAD;
      ST_LOAD:  if (st.last_pending) state_next = ST_R_RD;
      ST_R_RD:  state_next = st.root_end ? ST_DONE : ST_R_CHK;
      ST_R_CHK: state_next = st.vis_set ? ST_R_RD : ST_Q_RD;
      ST_Q_RD:  state_next = st.q_empty ? ST_R_RD : ST_Q_DAT;
      ST_Q_DAT: state_next = ST_L_DAT;
      ST_L_DAT: state_next = ST_N_RD;
      ST_N_RD:  state_next = st.k_end ? ST_Q_RD : ST_N_DAT;
      ST_N_DAT: state_next = st.nb_skip ? ST_N_RD : ST_V_CHK;
      ST_V_CHK: state_next = st.vis_set ? ST_DONE : ST_N_RD;
      ST_DONE:  if (!st.out_busy) state_next = ST_CLEAR;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_CLEAR: cmd.clr_en = 1'b1;
      ST_LOAD: begin
        cmd.accept_ok = !st.last_pending;
        cmd.walk_init = st.last_pending;
      end
      ST_R_RD:  cmd.root_rd = !st.root_end;
      ST_R_CHK: begin
        cmd.root_mark = !st.vis_set;
        cmd.root_next = st.vis_set;
      end
      ST_Q_RD: begin
        cmd.q_rd      = !st.q_empty;
        cmd.root_next = st.q_empty;
      end
      ST_Q_DAT: cmd.cur_load = 1'b1;
      ST_L_DAT: cmd.len_load = 1'b1;
      ST_N_RD:  cmd.n_rd = !st.k_end;
      ST_N_DAT: cmd.nb_take = 1'b1;
      ST_V_CHK: begin
        cmd.mark_nb = !st.vis_set;
        cmd.found   = st.vis_set;
      end
      ST_DONE:  cmd.finish = !st.out_busy;
      default:  cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/ucd_datapath.sv =====
// datapath of the undirected cycle detector: adjacency, length, visited
// and queue memories, load pipeline, walk registers; depends on ucd_pkg
`default_nettype none
module ucd_datapath #(
  parameter int MAX_VERTICES = ucd_pkg::DEF_MAX_VERTICES,
  parameter int MAX_DEGREE   = ucd_pkg::DEF_MAX_DEGREE
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire ucd_pkg::cmd_t             cmd,
  output ucd_pkg::status_t               st,
  input  wire logic                      s_tvalid,
  input  wire logic [ucd_pkg::IN_W-1:0]  s_tdata,
  input  wire logic                      s_tlast,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [ucd_pkg::OUT_W-1:0]      m_tdata
);
  import ucd_pkg::*;

  localparam int VW   = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW   = $clog2(MAX_VERTICES + 1);
  localparam int LW   = $clog2(MAX_DEGREE + 1);
  localparam int DW   = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int CMPW = (CW > CNT_W) ? CW : CNT_W;
  localparam int QW   = 2 * VW + 1;

  // memories
  logic [VTX_W-1:0] nstore [2**(VW+DW)];
  logic [LW-1:0]    lenmem [MAX_VERTICES];
  logic             vismem [MAX_VERTICES];
  logic [QW-1:0]    queue  [MAX_VERTICES];

  logic [VTX_W-1:0] ns_q;
  logic [LW-1:0]    len_q;
  logic             vis_q;
  logic [QW-1:0]    q_q;

  // input word fields
  logic [VTX_W-1:0] in_vtx, in_nb;
  logic             in_edge;
  logic [CNT_W-1:0] in_cnt;
  logic             accept;

  assign in_vtx  = s_tdata[VTX_W-1:0];
  assign in_nb   = s_tdata[2*VTX_W-1:VTX_W];
  assign in_edge = s_tdata[2*VTX_W];
  assign in_cnt  = s_tdata[2*VTX_W+CNT_W:2*VTX_W+1];
  assign accept  = s_tvalid && cmd.accept_ok;

  // load stage registers
  logic             p_valid, p_we, p_last;
  logic [VW-1:0]    p_vtx;
  logic [VTX_W-1:0] p_nb;
  logic             wr_valid;
  logic [VW-1:0]    wr_vtx;
  logic [LW-1:0]    wr_len;
  logic [LW-1:0]    len_cur;
  logic             ovf;
  logic [CW-1:0]    count;

  // walk registers
  logic [VW-1:0]    clr_addr;
  logic [CW-1:0]    root, head, tail;
  logic [VW-1:0]    cur_vtx, cur_par;
  logic             cur_pok;
  logic [LW-1:0]    cur_len, k;
  logic [VW-1:0]    nb_q;
  logic             cycle_r;
  logic             out_cyc, out_ovf;

  logic [VW-1:0]    len_addr, vis_addr;
  logic             vis_we;

  assign len_cur = (wr_valid && wr_vtx == p_vtx) ? wr_len : len_q;
  assign len_addr = cmd.cur_load ? q_q[QW-1:VW+1] : VW'(in_vtx);

  always_comb begin
    vis_addr = VW'(ns_q);
    if (cmd.clr_en) begin
      vis_addr = clr_addr;
    end else if (cmd.root_rd || cmd.root_mark) begin
      vis_addr = root[VW-1:0];
    end else if (cmd.mark_nb) begin
      vis_addr = nb_q;
    end
  end
  assign vis_we = cmd.clr_en || cmd.root_mark || cmd.mark_nb;

  always_ff @(posedge clk) begin
    len_q <= lenmem[len_addr];
    if (cmd.clr_en) begin
      lenmem[clr_addr] <= '0;
    end else if (p_valid && p_we && len_cur < LW'(MAX_DEGREE)) begin
      lenmem[p_vtx] <= len_cur + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (p_valid && p_we && len_cur < LW'(MAX_DEGREE)) begin
      nstore[{p_vtx, len_cur[DW-1:0]}] <= p_nb;
    end
    if (cmd.n_rd) begin
      ns_q <= nstore[{cur_vtx, k[DW-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (vis_we) begin
      vismem[vis_addr] <= !cmd.clr_en;
    end
    vis_q <= vismem[vis_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.root_mark) begin
      queue[0] <= {root[VW-1:0], {VW{1'b0}}, 1'b0};
    end else if (cmd.mark_nb && tail < CW'(MAX_VERTICES)) begin
      queue[tail[VW-1:0]] <= {nb_q, cur_vtx, 1'b1};
    end
    if (cmd.q_rd) begin
      q_q <= queue[head[VW-1:0]];
    end
  end

  // load pipeline and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid  <= 1'b0;
      wr_valid <= 1'b0;
      ovf      <= 1'b0;
      m_tvalid <= 1'b0;
      clr_addr <= '0;
    end else begin
      p_valid <= accept;
      if (cmd.clr_en) begin
        clr_addr <= clr_addr + VW'(1);
      end
      if (p_valid && p_we) begin
        if (len_cur < LW'(MAX_DEGREE)) begin
          wr_valid <= 1'b1;
        end else begin
          ovf <= 1'b1;
        end
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.finish) begin
        m_tvalid <= 1'b1;
        ovf      <= 1'b0;
        wr_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_vtx  <= VW'(in_vtx);
      p_nb   <= in_nb;
      p_we   <= in_edge && (CMPW'(in_vtx) < CMPW'(MAX_VERTICES));
      p_last <= s_tlast;
      if (s_tlast) begin
        if (CMPW'(in_cnt) > CMPW'(MAX_VERTICES)) begin
          count <= CW'(MAX_VERTICES);
        end else begin
          count <= CW'(in_cnt);
        end
      end
    end
    if (p_valid && p_we && len_cur < LW'(MAX_DEGREE)) begin
      wr_vtx <= p_vtx;
      wr_len <= len_cur + LW'(1);
    end
    if (cmd.walk_init) begin
      root    <= '0;
      cycle_r <= 1'b0;
    end
    if (cmd.root_next) begin
      root <= root + CW'(1);
    end
    if (cmd.root_mark) begin
      head <= '0;
      tail <= CW'(1);
    end
    if (cmd.cur_load) begin
      cur_vtx <= q_q[QW-1:VW+1];
      cur_par <= q_q[VW:1];
      cur_pok <= q_q[0];
      head    <= head + CW'(1);
    end
    if (cmd.len_load) begin
      cur_len <= len_q;
      k       <= '0;
    end
    if (cmd.nb_take) begin
      nb_q <= VW'(ns_q);
      k    <= k + LW'(1);
    end
    if (cmd.mark_nb && tail < CW'(MAX_VERTICES)) begin
      tail <= tail + CW'(1);
    end
    if (cmd.found) begin
      cycle_r <= 1'b1;
    end
    if (cmd.finish) begin
      out_cyc <= cycle_r;
      out_ovf <= ovf;
    end
  end

  assign m_tdata = {{(OUT_W-2){1'b0}}, out_ovf, out_cyc};

  always_comb begin
    st.last_pending = p_valid && p_last;
    st.clr_last     = clr_addr == VW'(MAX_VERTICES - 1);
    st.root_end     = root == count;
    st.vis_set      = vis_q;
    st.q_empty      = head == tail;
    st.k_end        = k == cur_len;
    st.nb_skip      = (CMPW'(ns_q) >= CMPW'(count))
                      || (cur_pok && CMPW'(ns_q) == CMPW'(cur_par));
    st.out_busy     = m_tvalid;
  end

endmodule
`default_nettype wire

// ===== design/undirected_cycle_detect_core.sv =====
// top level of the undirected cycle detector
// depends on ucd_pkg, ucd_ctrl and ucd_datapath
//
// slave stream: one adjacency word per cycle in the loading state (vertex,
// neighbor, has_edge, vertex_count); tlast marks the final word of a graph
// and starts the walk. master stream: one result word per graph
// (cycle_found, list_overflow). loading takes one word per cycle through a
// two-stage read-modify-write of the list length memory. after the last
// word the breadth-first walk runs over the memories: it probes roots,
// dequeues vertices, reads their lists, skips or follows each list entry
// and posts the result. afterwards a clearing pass resets list lengths and
// visited bits; no word is accepted then. the same pass runs after reset.
// a waiting result does not block loading of the next graph; the walk of
// that graph holds its result until the receiver takes the earlier one.
// rst is synchronous and active high.
`default_nettype none
module undirected_cycle_detect_core #(
  parameter int MAX_VERTICES = ucd_pkg::DEF_MAX_VERTICES,
  parameter int MAX_DEGREE   = ucd_pkg::DEF_MAX_DEGREE
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  // vertex[9:0], neighbor[19:10], has_edge[20], vertex_count[31:21]
  input  wire logic [ucd_pkg::IN_W-1:0]  s_tdata,
  input  wire logic                      s_tlast,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  // cycle_found[0], list_overflow[1], zero[7:2]
  output logic [ucd_pkg::OUT_W-1:0]      m_tdata
);
  import ucd_pkg::*;

  cmd_t    cmd;
  status_t st;
  state_t  state;

  ucd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .st    (st),
    .cmd   (cmd),
    .state (state)
  );

  ucd_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_DEGREE   (MAX_DEGREE)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .s_tvalid (s_tvalid),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  assign s_tready = cmd.accept_ok;

  a_no_accept_walk: assert property (@(posedge clk) disable iff (rst)
    st.last_pending |-> !s_tready)
    else $error("word accepted while a graph is pending");

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !m_tvalid)
    else $error("result posted over a waiting result");

  a_mark_unvisited: assert property (@(posedge clk) disable iff (rst)
    cmd.mark_nb |-> (state == ST_V_CHK && !st.vis_set))
    else $error("visited vertex queued again");

  a_accept_in_load: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == ST_LOAD)
    else $error("ready outside of loading");

endmodule
`default_nettype wire

// ===== bench/tb_undirected_cycle_detect_core.sv =====
// self-checking bench for undirected_cycle_detect_core: directed and random graphs,
// a breadth-first cycle predictor and a scoreboard on the result stream
// depends on ucd_pkg and the core RTL only
`default_nettype none
module tb_undirected_cycle_detect_core;
  import ucd_pkg::*;

  localparam int MAXV = DEF_MAX_VERTICES;
  localparam int MAXD = DEF_MAX_DEGREE;
  localparam int STALL_LIMIT = 200000;

  typedef struct packed {
    logic [VTX_W-1:0] vtx;
    logic [VTX_W-1:0] nbr;
    logic             has_edge;
    logic [CNT_W-1:0] cnt;
    logic             last;
  } adj_word_t;

  typedef struct packed {
    logic cycle;
    logic overflow;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  adj_word_t pend_q[$];
  verdict_t verdict_q[$];
  adj_word_t cur_w;
  int s_idle_pct = 0;
  int r_idle_pct = 0;
  int err_cnt = 0;
  int word_cnt = 0;
  int graph_cnt = 0;
  int result_cnt = 0;
  int cycle_cnt = 0;
  int stall_cyc = 0;

  // predictor state
  logic [VTX_W-1:0] nbr_mem[MAXV][MAXD];
  int len_mem[MAXV];
  bit visited[MAXV];
  int wq_vtx[MAXV];
  int wq_par[MAXV];
  bit wq_ok[MAXV];
  bit ovf_seen = 0;

  always #2 clk = ~clk;

  undirected_cycle_detect_core u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  function automatic bit walk_component(int root, int cnt);
    int head;
    int tail;
    int cv;
    int nb;
    head = 0;
    tail = 1;
    visited[root] = 1;
    wq_vtx[0] = root;
    wq_par[0] = 0;
    wq_ok[0] = 0;
    while (head < tail) begin
      cv = wq_vtx[head];
      for (int k = 0; k < len_mem[cv]; k++) begin
        nb = int'(nbr_mem[cv][k]);
        if (nb >= cnt) continue;
        if (wq_ok[head] && nb == wq_par[head]) continue;
        if (visited[nb]) return 1;
        visited[nb] = 1;
        if (tail < MAXV) begin
          wq_vtx[tail] = nb;
          wq_par[tail] = cv;
          wq_ok[tail] = 1;
          tail++;
        end
      end
      head++;
    end
    return 0;
  endfunction

  task automatic absorb_word(input adj_word_t w);
    int cnt;
    bit cyc;
    if (w.has_edge) begin
      if (len_mem[w.vtx] < MAXD) begin
        nbr_mem[w.vtx][len_mem[w.vtx]] = w.nbr;
        len_mem[w.vtx]++;
      end else begin
        ovf_seen = 1;
      end
    end
    if (w.last) begin
      cnt = (w.cnt > MAXV) ? MAXV : int'(w.cnt);
      cyc = 0;
      for (int v = 0; v < cnt && !cyc; v++)
        if (!visited[v]) cyc = walk_component(v, cnt);
      verdict_q.push_back('{cyc, ovf_seen});
      if (cyc) cycle_cnt++;
      for (int v = 0; v < MAXV; v++) begin
        len_mem[v] = 0;
        visited[v] = 0;
      end
      ovf_seen = 0;
      graph_cnt++;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tlast <= 1'b0;
      s_tdata <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        absorb_word(cur_w);
        word_cnt++;
      end
      if (!s_tvalid || s_tready) begin
        if (pend_q.size() > 0 && $urandom_range(0, 99) >= s_idle_pct) begin
          cur_w = pend_q.pop_front();
          s_tvalid <= 1'b1;
          s_tlast <= cur_w.last;
          s_tdata <= {cur_w.cnt, cur_w.has_edge, cur_w.nbr, cur_w.vtx};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor, receiver stalls and watchdog
  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        result_cnt++;
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result word %h", m_tdata));
        end else begin
          exp_v = verdict_q.pop_front();
          if (m_tdata[0] !== exp_v.cycle)
            report_mismatch($sformatf("cycle_found %b, expected %b", m_tdata[0], exp_v.cycle));
          if (m_tdata[1] !== exp_v.overflow)
            report_mismatch($sformatf("list_overflow %b, expected %b",
                                      m_tdata[1], exp_v.overflow));
          if (m_tdata[OUT_W-1:2] !== '0)
            report_mismatch($sformatf("padding bits %b not zero", m_tdata[OUT_W-1:2]));
        end
      end
      m_tready <= ($urandom_range(0, 99) >= r_idle_pct);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cyc = 0;
      else stall_cyc++;
      if (stall_cyc >= STALL_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", verdict_q.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic push_word(input int v, input int nb, input bit he, input int cnt, input bit lst);
    adj_word_t w;
    w.vtx = VTX_W'(v);
    w.nbr = VTX_W'(nb);
    w.has_edge = he;
    w.cnt = CNT_W'(cnt);
    w.last = lst;
    pend_q.push_back(w);
  endtask

  // one random graph; most are small random forests, some with extra edges
  task automatic make_graph();
    adj_word_t gq[$];
    adj_word_t w;
    adj_word_t t;
    int lbl[];
    int n;
    int cnt;
    int kind;
    int a;
    int b;
    int j;
    int edges;
    kind = $urandom_range(0, 19);
    n = (kind == 0) ? $urandom_range(512, MAXV) : $urandom_range(2, 12);
    lbl = new[n];
    for (int i = 0; i < n; i++) lbl[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      a = lbl[i];
      lbl[i] = lbl[j];
      lbl[j] = a;
    end
    edges = 0;
    for (int i = 1; i < n && kind != 0; i++) begin
      if ($urandom_range(0, 4) == 0) continue;
      a = lbl[i];
      b = lbl[$urandom_range(0, i - 1)];
      w = '{vtx: VTX_W'(a), nbr: VTX_W'(b), has_edge: 1'b1, cnt: CNT_W'($urandom),
            last: 1'b0};
      gq.push_back(w);
      w.vtx = VTX_W'(b); w.nbr = VTX_W'(a); w.cnt = CNT_W'($urandom);
      if ($urandom_range(0, 15) != 0) gq.push_back(w);
    end
    // extra edges: random, self loops, parallel edges; big graphs are sparse
    edges = (kind == 0) ? $urandom_range(0, 20) : $urandom_range(0, 2);
    for (int e = 0; e < edges; e++) begin
      a = $urandom_range(0, n - 1);
      b = ($urandom_range(0, 7) == 0) ? a : $urandom_range(0, n - 1);
      w = '{vtx: VTX_W'(a), nbr: VTX_W'(b), has_edge: 1'b1, cnt: CNT_W'($urandom),
            last: 1'b0};
      gq.push_back(w);
      w.vtx = VTX_W'(b); w.nbr = VTX_W'(a);
      gq.push_back(w);
    end
    // noise: empty words, random entries, neighbors out of range
    for (int e = $urandom_range(0, 3); e > 0; e--) begin
      w = '{vtx: VTX_W'($urandom), nbr: VTX_W'($urandom),
            has_edge: 1'($urandom_range(0, 1)), cnt: CNT_W'($urandom), last: 1'b0};
      if ($urandom_range(0, 1)) w.vtx = VTX_W'($urandom_range(0, n - 1));
      gq.push_back(w);
    end
    if (kind == 1) begin
      a = $urandom_range(0, n - 1);
      for (int e = $urandom_range(MAXD - 1, MAXD + 3); e > 0; e--) begin
        w = '{vtx: VTX_W'(a), nbr: VTX_W'($urandom), has_edge: 1'b1,
              cnt: CNT_W'($urandom), last: 1'b0};
        gq.push_back(w);
      end
    end
    for (int i = gq.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = gq[i];
      gq[i] = gq[j];
      gq[j] = t;
    end
    case ($urandom_range(0, 9))
      0: cnt = $urandom_range(0, n);
      1: cnt = $urandom_range(MAXV, (1 << CNT_W) - 1);
      default: cnt = n;
    endcase
    if (gq.size() == 0 || $urandom_range(0, 3) == 0)
      gq.push_back('{vtx: VTX_W'($urandom), nbr: VTX_W'($urandom), has_edge: 1'b0,
                     cnt: CNT_W'(0), last: 1'b0});
    gq[gq.size() - 1].last = 1'b1;
    gq[gq.size() - 1].cnt = CNT_W'(cnt);
    foreach (gq[i]) pend_q.push_back(gq[i]);
  endtask

  task automatic drain();
    @(negedge clk);
    while (pend_q.size() > 0 || s_tvalid || verdict_q.size() > 0) @(negedge clk);
  endtask

  initial begin
    int target;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty graph, saturated count with self loop, full list, parallel edge
    push_word(0, 0, 0, 0, 1);
    push_word(MAXV - 1, MAXV - 1, 1, (1 << CNT_W) - 1, 1);
    for (int i = 0; i <= MAXD; i++) push_word(0, MAXV - 1, 1, 0, 0);
    push_word(0, 0, 0, 1, 1);
    push_word(0, 1, 1, 0, 0);
    push_word(1, 0, 1, 0, 0);
    push_word(0, 1, 1, 2, 1);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin s_idle_pct = 0;  r_idle_pct = 0;  end
        1: begin s_idle_pct = 86; r_idle_pct = 0;  end
        2: begin s_idle_pct = 0;  r_idle_pct = 86; end
        default: begin s_idle_pct = 11; r_idle_pct = 11; end
      endcase
      target = word_cnt + 175;
      while (word_cnt + pend_q.size() < target) make_graph();
      drain();
    end

    repeat (1500) @(posedge clk);
    $display("%0d adjacency words in %0d graphs, %0d results checked (%0d with a cycle)",
             word_cnt, graph_cnt, result_cnt, cycle_cnt);
    if (err_cnt == 0 && verdict_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results missing", err_cnt, verdict_q.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
